@@ hdl/stpv_pkg.sv @@
// Package with shared types, constants and codes for the sorted table with prime view.
package stpv_pkg;

  localparam int DEF_CAPACITY = 64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_PRIME  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_CMP,
    S_SHL_RD,
    S_SHL_WR,
    S_READ_RD,
    S_READ_WAIT,
    S_PRM_RD,
    S_PRM_CHK,
    S_DONE
  } state_t;

  // States of the primality unit.
  typedef enum logic [1:0] {P_IDLE, P_SQR, P_DIV, P_OUT} pstate_t;

  // Handshake between the controller and the primality unit.
  typedef struct packed {
    logic start;
  } prime_req_t;

  typedef struct packed {
    logic done;
    logic is_prime;
  } prime_rsp_t;

endpackage

@@ hdl/stpv_prime.sv @@
// Iterative trial-division primality unit, one odd divisor per remainder pass.
module stpv_prime
  import stpv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  prime_req_t        req,
  input  logic signed [31:0] value,
  output prime_rsp_t        rsp
);

  pstate_t     pstate;
  logic [31:0] n;
  logic [31:0] d;
  logic [63:0] sq;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [5:0]  bitn;
  logic        result;

  // Square of the current divisor for the end-of-search check.
  assign sq = {32'd0, d} * {32'd0, d};

  // Trial division: for each odd d, check d*d <= n, then a bit-serial remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      rsp    <= '0;
    end else begin
      rsp.done <= 1'b0;
      case (pstate)
        P_IDLE: begin
          if (req.start) begin
            n <= value;
            d <= 32'd3;
            if (value < 2) begin
              result <= 1'b0;
              pstate <= P_OUT;
            end else if (value == 2) begin
              result <= 1'b1;
              pstate <= P_OUT;
            end else if (!value[0]) begin
              result <= 1'b0;
              pstate <= P_OUT;
            end else begin
              pstate <= P_SQR;
            end
          end
        end
        P_SQR: begin
          if (sq > {32'd0, n}) begin
            result <= 1'b1;
            pstate <= P_OUT;
          end else begin
            rem    <= '0;
            quo    <= n;
            bitn   <= 6'd32;
            pstate <= P_DIV;
          end
        end
        P_DIV: begin
          if (bitn == 6'd0) begin
            if (rem == 32'd0) begin
              result <= 1'b0;
              pstate <= P_OUT;
            end else begin
              d      <= d + 32'd2;
              pstate <= P_SQR;
            end
          end else begin
            if ({rem[30:0], quo[31]} >= d) begin
              rem <= {rem[30:0], quo[31]} - d;
            end else begin
              rem <= {rem[30:0], quo[31]};
            end
            quo  <= {quo[30:0], 1'b0};
            bitn <= bitn - 6'd1;
          end
        end
        default: begin
          rsp.done     <= 1'b1;
          rsp.is_prime <= result;
          pstate       <= P_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/sorted_table_with_prime_view_core.sv @@
// Top level: sorted table of signed values with a derived view of the prime entries.
// One item is taken while busy is low and start is high; its single result appears
// on data, status, count and prime_count for one cycle with done high, and must be
// captured then, since the receiver cannot hold it. Each item is served from one
// synchronous memory (value and prime mark per entry) with one read port and one write port.
// An insert costs the primality test (for an odd value, one pass per odd divisor up to
// the square root, each a square check and a bit-serial remainder) plus a read and a
// write per shifted entry; a remove reads and compares each entry scanned, then reads
// and writes each entry shifted; a rank read reads one entry; a prime read walks the
// table, reading and checking each entry until the requested prime or the table's end.
module sorted_table_with_prime_view_core
  import stpv_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] value,
  input  logic [5:0]         rank,
  output logic               done,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic [6:0]         count,
  output logic [6:0]         prime_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  // Entry memory: prime mark above the value bits.
  logic [32:0] mem [CAPACITY];
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [32:0] mem_wdata, mem_rdata;

  logic [CW-1:0] ecount, pcount;
  logic [CW-1:0] pos;
  logic [CW-1:0] seen;
  logic signed [31:0] op_value;
  logic [5:0]    op_rank;
  logic          op_prime;
  prime_req_t    preq;
  prime_rsp_t    prsp;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  stpv_prime u_prime (
    .clk   (clk),
    .rst   (rst),
    .req   (preq),
    .value (value),
    .rsp   (prsp)
  );

  assign busy = (state != S_IDLE);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (kind_t'(kind))
            KIND_INSERT: state_next = (CW'(CAPACITY) <= ecount) ? S_DONE : S_PRIME;
            KIND_REMOVE: state_next = (ecount == '0) ? S_DONE : S_REM_RD;
            KIND_READ:   state_next = ({{(CW > 6 ? CW-6 : 1){1'b0}}, rank} >= ecount) ?
                                      S_DONE : S_READ_RD;
            default:     state_next = ({{(CW > 6 ? CW-6 : 1){1'b0}}, rank} >= pcount) ?
                                      S_DONE : S_PRM_RD;
          endcase
        end
      end
      S_PRIME:     if (prsp.done) state_next = (pos == '0) ? S_INS_PUT : S_INS_RD;
      S_INS_RD:    state_next = S_INS_WR;
      S_INS_WR:    state_next = ($signed(mem_rdata[31:0]) > op_value && pos != '0) ?
                                ((pos == CW'(1)) ? S_INS_PUT : S_INS_RD) : S_INS_PUT;
      S_INS_PUT:   state_next = S_DONE;
      S_REM_RD:    state_next = S_REM_CMP;
      S_REM_CMP: begin
        if ($signed(mem_rdata[31:0]) == op_value)
          state_next = (pos + CW'(1) < ecount) ? S_SHL_RD : S_DONE;
        else if (pos + CW'(1) >= ecount) state_next = S_DONE;
        else state_next = S_REM_RD;
      end
      S_SHL_RD:    state_next = S_SHL_WR;
      S_SHL_WR:    state_next = (pos + CW'(1) < ecount) ? S_SHL_RD : S_DONE;
      S_READ_RD:   state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_DONE;
      S_PRM_RD:    state_next = S_PRM_CHK;
      S_PRM_CHK:   state_next = (mem_rdata[32] && seen == CW'(op_rank)) ? S_DONE :
                                (pos + CW'(1) >= ecount) ? S_DONE : S_PRM_RD;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = pos[AW-1:0];
    preq.start = (state == S_IDLE) && start && (kind_t'(kind) == KIND_INSERT) &&
                 (CW'(CAPACITY) > ecount);
    unique case (state)
      S_INS_RD:  mem_raddr = AW'(pos - CW'(1));
      S_INS_WR: begin
        if ($signed(mem_rdata[31:0]) > op_value) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = {op_prime, op_value};
      end
      S_SHL_RD:  mem_raddr = AW'(pos + CW'(1));
      S_SHL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_READ_RD: mem_raddr = AW'(op_rank);
      default: ;
    endcase
  end

  // Datapath registers and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ecount <= '0;
      pcount <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          op_value <= value;
          op_rank  <= rank;
          data     <= '0;
          seen     <= '0;
          if (kind_t'(kind) == KIND_INSERT) begin
            pos    <= ecount;
            status <= (CW'(CAPACITY) <= ecount) ? ST_FULL : ST_OK;
          end else begin
            pos <= '0;
            if (kind_t'(kind) == KIND_REMOVE) status <= ST_NOT_FOUND;
            else if (kind_t'(kind) == KIND_READ)
              status <= ({{(CW > 6 ? CW-6 : 1){1'b0}}, rank} >= ecount) ? ST_RANGE : ST_OK;
            else status <= ST_RANGE;
          end
        end
        S_PRIME: if (prsp.done) op_prime <= prsp.is_prime;
        S_INS_WR: if ($signed(mem_rdata[31:0]) > op_value) pos <= pos - CW'(1);
        S_INS_PUT: begin
          ecount <= ecount + CW'(1);
          if (op_prime) pcount <= pcount + CW'(1);
        end
        S_REM_CMP: begin
          if ($signed(mem_rdata[31:0]) == op_value) begin
            status <= ST_OK;
            ecount <= ecount - CW'(1);
            if (mem_rdata[32] && pcount != '0) pcount <= pcount - CW'(1);
          end else begin
            pos <= pos + CW'(1);
          end
        end
        S_SHL_WR: pos <= pos + CW'(1);
        S_READ_WAIT: data <= mem_rdata[31:0];
        S_PRM_CHK: begin
          if (mem_rdata[32]) begin
            if (seen == CW'(op_rank)) begin
              data   <= mem_rdata[31:0];
              status <= ST_OK;
            end
            seen <= seen + CW'(1);
          end
          pos <= pos + CW'(1);
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // Counts are reported in their low seven bits.
  assign count       = 7'(ecount);
  assign prime_count = 7'(pcount);

endmodule
